[hw/rtl/bmes_pkg.sv]
// ----------------------------------------------------------------------------
// bmes_pkg - shared types and constants
// Command and status structures between controller and datapath.
// ----------------------------------------------------------------------------
package bmes_pkg;

	localparam int POS_W  = 33;
	localparam int VTX_W  = 18;
	localparam int BLK_W  = 2;

	localparam logic [2:0] REG_DIRECTED = 3'd0;
	localparam logic [2:0] REG_LOOPS    = 3'd1;
	localparam logic [2:0] REG_COUNT    = 3'd2;
	localparam logic [2:0] REG_SIZE0    = 3'd3;
	localparam logic [2:0] REG_SIZE1    = 3'd4;
	localparam logic [2:0] REG_SIZE2    = 3'd5;
	localparam logic [2:0] REG_SIZE3    = 3'd6;

	typedef struct packed {
		logic start;     // take a new item, run position update
		logic map_start; // start divide / root unit
		logic finish_map;// capture mapped edge
		logic advance;   // move to next pair
	} dp_cmd_t;

	typedef struct packed {
		logic restart;
		logic done;      // walk finished
		logic bad_pair;  // pair beyond block count; tied low in the datapath
		logic hit;       // position below edge count
		logic unit_busy;
	} dp_sts_t;

endpackage

[hw/rtl/bmes_iter_unit.sv]
// ----------------------------------------------------------------------------
// bmes_iter_unit - shared bit-serial divider and integer square root
// Restoring divide (36 steps) or digit-pair square root (18 steps).
// ----------------------------------------------------------------------------
module bmes_iter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        sqrt_mode,
	input  logic [35:0] operand,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [35:0] quotient,
	output logic [35:0] remainder
);
	import bmes_pkg::*;

	logic [5:0]  cnt_q;
	logic        mode_q;
	logic [35:0] num_q;
	logic [35:0] quo_q;
	logic [37:0] rem_q;
	logic [15:0] div_q;

	logic [37:0] rem_sh;
	logic [37:0] trial;
	logic        ok;

	always_comb begin
		if (mode_q) begin
			rem_sh = {rem_q[35:0], num_q[35:34]};
			trial  = {quo_q[35:0], 2'b01};
		end else begin
			rem_sh = {rem_q[36:0], num_q[35]};
			trial  = {22'd0, div_q};
		end
		ok = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= sqrt_mode ? 6'd18 : 6'd36;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= sqrt_mode;
			num_q  <= operand;
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (cnt_q != '0) begin
			num_q <= mode_q ? {num_q[33:0], 2'b00} : {num_q[34:0], 1'b0};
			quo_q <= {quo_q[34:0], ok};
			rem_q <= ok ? rem_sh - trial : rem_sh;
		end
	end

	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q[35:0];

endmodule

[hw/rtl/bmes_datapath.sv]
// ----------------------------------------------------------------------------
// bmes_datapath - pair walk state, position update and edge mapping
// Holds registers, walk state and the result register.
// ----------------------------------------------------------------------------
module bmes_datapath #(
	parameter int MAX_BLOCKS = 4,
	parameter int SIZE_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [31:0]          gap,
	input  logic                 restart,
	input  bmes_pkg::dp_cmd_t    cmd,
	output bmes_pkg::dp_sts_t    sts,
	output logic [41:0]          result
);
	import bmes_pkg::*;

	logic       directed_q, loops_q;
	logic [2:0] count_q;
	logic [15:0] size_q [4];

	logic [1:0]       fb_q, tb_q;
	logic [POS_W-1:0] pos_q;
	logic             started_q, done_q;
	logic [VTX_W-1:0] foff_q, toff_q;
	logic             restart_q;
	logic [35:0]      maxe_q;
	logic [41:0]      res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			directed_q <= 1'b0;
			loops_q    <= 1'b0;
			count_q    <= 3'd1;
			for (int i = 0; i < 4; i++) size_q[i] <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_DIRECTED: directed_q <= cfg_data[0];
				REG_LOOPS:    loops_q    <= cfg_data[0];
				REG_COUNT:    count_q    <= cfg_data[2:0];
				REG_SIZE0:    size_q[0]  <= cfg_data;
				REG_SIZE1:    size_q[1]  <= cfg_data;
				REG_SIZE2:    size_q[2]  <= cfg_data;
				REG_SIZE3:    size_q[3]  <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [15:0] sz(input logic [15:0] v);
		sz = v & 16'((32'd1 << SIZE_BITS) - 1);
	endfunction

	logic [2:0]  nb;
	logic [15:0] fs, ts;
	logic        same, tri_m;
	logic [POS_W:0] sum;
	logic [POS_W-1:0] pos_n;

	assign nb    = (count_q > 3'(MAX_BLOCKS)) ? 3'(MAX_BLOCKS) : count_q;
	assign fs    = sz(size_q[fb_q]);
	assign ts    = sz(size_q[tb_q]);
	assign same  = (fb_q == tb_q);
	assign tri_m = same && !directed_q;
	assign sum   = {1'b0, pos_q} + {2'b0, gap} + 34'd1;
	assign pos_n = !started_q ? {1'b0, gap} : (sum[POS_W] ? '1 : sum[POS_W-1:0]);

	// edge count, registered before the compare
	logic [31:0] prod;
	logic [16:0] fsp, fsm;
	assign fsp = {1'b0, fs} + 17'd1;
	assign fsm = (fs == '0) ? 17'd0 : {1'b0, fs} - 17'd1;
	always_comb begin
		if (!same)                prod = fs * ts;
		else if (directed_q)      prod = loops_q ? fs * fs : {16'd0, fs} * {15'd0, fsm};
		else if (loops_q)         prod = 32'(({17'd0, fs} * {17'd0, fsp}) >> 1);
		else                      prod = 32'(({17'd0, fs} * {17'd0, fsm}) >> 1);
	end

	// mapping unit
	logic        u_busy;
	logic [35:0] u_q, u_r;
	bmes_iter_unit u_iter (
		.clk(clk), .arst_n(arst_n), .start(cmd.map_start), .sqrt_mode(tri_m),
		.operand(tri_m ? ({3'd0, pos_q} << 3) + 36'd1 : {3'd0, pos_q}),
		.divisor(fs), .busy(u_busy), .quotient(u_q), .remainder(u_r)
	);

	// map finish: one multiply for the triangle base
	logic [17:0] col, row;
	logic [35:0] tbase;
	logic [17:0] s;
	assign s = u_q[17:0];
	always_comb begin
		tbase = '0;
		if (tri_m) begin
			col   = loops_q ? (s - 18'd1) >> 1 : (s + 18'd1) >> 1;
			tbase = loops_q ? ({18'd0, col} * {18'd0, col + 18'd1}) >> 1
			                : ({18'd0, col} * {18'd0, col - 18'd1}) >> 1;
			row   = 18'(pos_q - tbase[32:0]);
		end else begin
			col = u_q[17:0];
			row = u_r[17:0];
			if (same && directed_q && !loops_q && row == col) col = {2'b0, fs} - 18'd1;
		end
	end

	// pair advance
	logic [17:0] toff_sum;
	always_comb begin
		toff_sum = '0;
		for (int b = 0; b < 4; b++)
			if (b < 3'(fb_q) + 3'd1) toff_sum = toff_sum + {2'b0, sz(size_q[b])};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q <= '0; tb_q <= '0; pos_q <= '0; started_q <= 1'b0;
			foff_q <= '0; toff_q <= '0; done_q <= 1'b0; restart_q <= 1'b0;
		end else if (cmd.start) begin
			restart_q <= restart;
			if (restart) begin
				fb_q <= '0; tb_q <= '0; pos_q <= '0; started_q <= 1'b0;
				foff_q <= '0; toff_q <= '0; done_q <= 1'b0;
			end else if (!done_q) begin
				if ({1'b0, fb_q} >= nb || {1'b0, tb_q} >= nb) begin
					done_q <= 1'b1; started_q <= 1'b0; pos_q <= '0;
					fb_q <= '0; tb_q <= '0; foff_q <= '0; toff_q <= '0;
				end else begin
					pos_q     <= pos_n;
					started_q <= 1'b1;
				end
			end
		end else if (cmd.advance) begin
			started_q <= 1'b0; pos_q <= '0;
			if (3'(tb_q) + 3'd1 < nb) begin
				tb_q   <= tb_q + 2'd1;
				toff_q <= toff_q + {2'b0, ts};
			end else if (3'(fb_q) + 3'd1 >= nb) begin
				done_q <= 1'b1; fb_q <= '0; tb_q <= '0; foff_q <= '0; toff_q <= '0;
			end else begin
				foff_q <= foff_q + {2'b0, fs};
				fb_q   <= fb_q + 2'd1;
				tb_q   <= directed_q ? '0 : fb_q + 2'd1;
				toff_q <= directed_q ? '0 : toff_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) maxe_q <= {4'd0, prod};
	end

	logic hit;
	assign hit = {3'd0, pos_q} < maxe_q;

	// result register: valid, src, dst, fb, tb, finished
	logic [41:0] status_word;
	assign status_word = {1'b0, 18'd0, 18'd0,
	                      done_q ? 2'b00 : fb_q, done_q ? 2'b00 : tb_q, done_q};
	always_ff @(posedge clk) begin
		if (cmd.finish_map)
			res_q <= {1'b1, foff_q + row, toff_q + col, fb_q, tb_q, 1'b0};
		else if (cmd.advance || cmd.start)
			res_q <= '0;
	end

	assign result = (res_q[41]) ? res_q : status_word;

	assign sts.restart   = restart_q;
	assign sts.done      = done_q;
	assign sts.bad_pair  = 1'b0;
	assign sts.hit       = hit;
	assign sts.unit_busy = u_busy;

endmodule

[hw/rtl/bmes_ctrl.sv]
// ----------------------------------------------------------------------------
// bmes_ctrl - sequencer for one gap
// Accept, compare, map through the shared unit on a hit or advance the pair on a miss, emit one result beat.
// ----------------------------------------------------------------------------
module bmes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bmes_pkg::dp_sts_t sts,
	output bmes_pkg::dp_cmd_t cmd
);
	import bmes_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_MAP  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.start = in_ready && in_valid;
		if (state_q == S_EVAL) begin
			cmd.map_start = !sts.restart && !sts.done && sts.hit;
			cmd.advance   = !sts.restart && !sts.done && !sts.hit;
		end
		cmd.finish_map = (state_q == S_MAP);
	end

	// an invalid pair finishes the walk at the accept edge, so EVAL sees done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EVAL;
				S_EVAL: state_q <= cmd.map_start ? S_WAIT : S_OUT;
				S_WAIT: if (!sts.unit_busy) state_q <= S_MAP;
				S_MAP:  state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_onehot_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.map_start && cmd.advance)) else $error("map and advance together");
	a_map_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_map |=> out_valid) else $error("mapped edge not shown");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");

endmodule

[hw/rtl/block_model_edge_sampler_core.sv]
// ----------------------------------------------------------------------------
// block_model_edge_sampler_core - stochastic block model skip sampler
// Turns geometric skip lengths into vertex pairs, block pair by block pair.
// ----------------------------------------------------------------------------
// Channels: s_axis carries one gap per beat (tdata = gap, tuser = restart).
// m_axis returns one result beat per input beat; tdata from bit 0: edge_valid,
// source_vertex, target_vertex, next_from_block, next_to_block, finished.
// Config writes go over cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must issue them only while idle, the core itself does not enforce it.
// A beat that ends a pair, restarts or meets a finished walk goes from EVAL
// straight to the result; a beat that yields an edge runs the shared unit
// first, for a divide or for the triangular square root. One beat is in flight
// at a time and s_axis_tready returns in the cycle after the result is taken.
// Reset clears the walk to pair (0,0), block_count to 1 and sizes to 0.
// A stalled m_axis holds the result and s_axis_tready stays low.
// ----------------------------------------------------------------------------
module block_model_edge_sampler_core #(
	parameter int MAX_BLOCKS = 4,
	parameter int SIZE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // gap
	input  logic        s_axis_tuser,  // restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // edge_valid, source_vertex, target_vertex,
	                                   // next_from_block, next_to_block, finished
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import bmes_pkg::*;

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [41:0] res;

	assign cfg_ready = 1'b1;

	bmes_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .SIZE_BITS(SIZE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_wr(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .gap(s_axis_tdata), .restart(s_axis_tuser),
		.cmd(cmd), .sts(sts), .result(res)
	);

	bmes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .sts(sts), .cmd(cmd)
	);

	// res: {valid, src, dst, fb, tb, finished}
	assign m_axis_tdata = {6'd0, res[0], res[2:1], res[4:3], res[22:5], res[40:23],
	                       res[41]};

endmodule
